// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the strided mean RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SRM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SRM_ASSERT_IMP(label, ante, cons)
`define SRM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/srm_pkg.sv =====
// Package for the strided mean block: widths, register codes, result item type.
`timescale 1ns / 1ps
package srm_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_INNER   = 1024;
	localparam int COL_BITS    = $clog2(MAX_INNER);
	localparam int ILEN_BITS   = 11;
	localparam int ROW_BITS    = 16;
	localparam int ACC_BITS    = 32;
	localparam int RECIP_BITS  = 17;
	localparam int PROD_BITS   = ACC_BITS + RECIP_BITS + 1;
	localparam int MEAN_BITS   = 16;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 17;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = FIFO_AW + 1;
	localparam int OUT_TDATA_BITS = 32;

	localparam logic [RECIP_BITS-1:0] RECIP_ONE = RECIP_BITS'(65536);
	localparam logic signed [MEAN_BITS-1:0] MEAN_MAX = 16'sh7FFF;
	localparam logic signed [MEAN_BITS-1:0] MEAN_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_REDUCE_LEN = 2'd0,
		CFG_INNER_LEN  = 2'd1,
		CFG_RECIPROCAL = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                        block_end;
		logic [COL_BITS-1:0]         position;
		logic signed [MEAN_BITS-1:0] mean;
	} srm_result_t;
endpackage

// ===== rtl/srm_fifo.sv =====
// Output queue for result items; count is exported for input credit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srm_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  srm_pkg::srm_result_t         push_item,
	output logic                         m_valid,
	input  logic                         m_ready,
	output srm_pkg::srm_result_t         m_item,
	output logic [srm_pkg::FIFO_CW-1:0]  count
);
	import srm_pkg::*;

	srm_result_t          store_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign m_valid = (count_q != '0);
	assign pop     = m_valid && m_ready;
	assign m_item  = store_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	`SRM_ASSERT_IMP(a_no_overflow, push && !pop, count_q < FIFO_CW'(FIFO_DEPTH))
	`SRM_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + FIFO_CW'(1))
	`SRM_ASSERT_NXT(a_count_down, pop && !push, count_q == $past(count_q) - FIFO_CW'(1))
endmodule

// ===== rtl/strided_reduce_mean.sv =====
// Top level of the strided mean block: counters, accumulator memory, scaling pipeline.
//
// Input: s_axis_* carries one signed Q8.8 sample per item, row-major order.
// A block is reduce_len rows of inner_len samples. Only last-row samples give a
// result on m_axis_*: mean in tdata[15:0], position in tdata[25:16], tlast on
// the last position of the block.
// Config: cfg_index 0 reduce_len, 1 inner_len, 2 reciprocal (Q1.16). Writing
// either length restarts the block. Write only while the block is idle.
// Throughput: one item per cycle while s_axis_tready is high. The accumulator
// RAM is read at acceptance and written back in the next cycle; a same-position
// write in flight is forwarded, so back-to-back items on one position need no stall.
// An accepted item passes the RAM read at acceptance, then add/write, multiply,
// and saturate into the output queue.
// An 8-entry output queue absorbs receiver stalls; s_axis_tready drops once
// queue fill plus items in the pipeline reach 8, and rises as m_axis drains.
// Reset clears counters, valid flags and config registers to their defaults; the accumulator RAM
// is not cleared, as the first row of each block overwrites it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module strided_reduce_mean (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [15:0] sample
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [srm_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata, // [15:0] mean, [25:16] position
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [srm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import srm_pkg::*;

	logic [ROW_BITS-1:0]   reduce_len_q;
	logic [ILEN_BITS-1:0]  inner_len_q;
	logic [RECIP_BITS-1:0] recip_q;
	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;

	logic [COL_BITS-1:0]   ilen_m1;
	logic [ROW_BITS-1:0]   rlen_m1;
	logic [RECIP_BITS-1:0] recip_eff;
	logic [COL_BITS-1:0]   col;
	logic                  last_col;
	logic                  last_row;
	logic                  in_accept;
	logic                  len_write;

	logic signed [ACC_BITS-1:0] acc_mem [MAX_INNER];

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [COL_BITS-1:0]           col_s1;
	logic                          first_s1;
	logic                          last_row_s1;
	logic                          last_col_s1;
	logic signed [ACC_BITS-1:0]    rdata_s1;
	logic signed [ACC_BITS-1:0]    acc_s1;
	logic signed [ACC_BITS-1:0]    sample_ext;
	logic signed [ACC_BITS-1:0]    base_s1;

	logic                          valid_s2;
	logic signed [ACC_BITS-1:0]    acc_s2;
	logic [COL_BITS-1:0]           col_s2;
	logic                          last_row_s2;
	logic                          last_col_s2;

	logic                          valid_s3;
	logic signed [PROD_BITS-1:0]   prod_s3;
	logic [COL_BITS-1:0]           col_s3;
	logic                          last_col_s3;
	logic signed [PROD_BITS-FRAC_BITS-1:0] quot_s3;

	srm_result_t           push_item;
	srm_result_t           head_item;
	logic [FIFO_CW-1:0]    fifo_count;
	logic [1:0]            inflight;
	logic [FIFO_CW-1:0]    occupancy;

	// effective register values
	always_comb begin
		if (inner_len_q <= ILEN_BITS'(1)) begin
			ilen_m1 = '0;
		end else if (inner_len_q >= ILEN_BITS'(MAX_INNER)) begin
			ilen_m1 = COL_BITS'(MAX_INNER - 1);
		end else begin
			ilen_m1 = COL_BITS'(inner_len_q - ILEN_BITS'(1));
		end
		rlen_m1   = (reduce_len_q == '0) ? '0 : reduce_len_q - ROW_BITS'(1);
		recip_eff = (recip_q > RECIP_ONE) ? RECIP_ONE : recip_q;
		col       = (col_q >= ilen_m1) ? ilen_m1 : col_q;
		last_col  = (col_q >= ilen_m1);
		last_row  = (row_q >= rlen_m1);
	end

	assign cfg_ready = 1'b1;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		unique case (cfg_index) inside
			CFG_REDUCE_LEN, CFG_INNER_LEN: len_write = cfg_valid;
			default:                       len_write = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduce_len_q <= ROW_BITS'(1);
			inner_len_q  <= ILEN_BITS'(1);
			recip_q      <= RECIP_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REDUCE_LEN: reduce_len_q <= cfg_data[ROW_BITS-1:0];
				CFG_INNER_LEN:  inner_len_q  <= cfg_data[ILEN_BITS-1:0];
				CFG_RECIPROCAL: recip_q      <= cfg_data[RECIP_BITS-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (len_write) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col + COL_BITS'(1);
			end
		end
	end

	// accumulator RAM: read at acceptance, write back from stage 1
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_mem[col_s1] <= acc_s1;
		end
		rdata_s1 <= acc_mem[col];
	end

	always_comb begin
		sample_ext = ACC_BITS'(sample_s1);
		base_s1    = (valid_s2 && col_s2 == col_s1) ? acc_s2 : rdata_s1;
		acc_s1     = first_s1 ? sample_ext : base_s1 + sample_ext;
	end

	always_ff @(posedge clk) begin
		sample_s1   <= $signed(s_axis_tdata);
		col_s1      <= col;
		first_s1    <= (row_q == '0);
		last_row_s1 <= last_row;
		last_col_s1 <= last_col;
		acc_s2      <= acc_s1;
		col_s2      <= col_s1;
		last_row_s2 <= last_row_s1;
		last_col_s2 <= last_col_s1;
		prod_s3     <= acc_s2 * $signed({1'b0, recip_eff});
		col_s3      <= col_s2;
		last_col_s3 <= last_col_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && last_row_s2;
		end
	end

	// floor divide by 2^16 and saturate
	always_comb begin
		quot_s3 = $signed(prod_s3[PROD_BITS-1:FRAC_BITS]);
		if (quot_s3 > (PROD_BITS-FRAC_BITS)'(MEAN_MAX)) begin
			push_item.mean = MEAN_MAX;
		end else if (quot_s3 < (PROD_BITS-FRAC_BITS)'(MEAN_MIN)) begin
			push_item.mean = MEAN_MIN;
		end else begin
			push_item.mean = quot_s3[MEAN_BITS-1:0];
		end
		push_item.position  = col_s3;
		push_item.block_end = last_col_s3;
	end

	srm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s3),
		.push_item (push_item),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_item    (head_item),
		.count     (fifo_count)
	);

	assign inflight = {1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3};
	assign occupancy = fifo_count + FIFO_CW'(inflight);
	assign s_axis_tready = (occupancy < FIFO_CW'(FIFO_DEPTH));

	assign m_axis_tdata = {(OUT_TDATA_BITS - COL_BITS - MEAN_BITS)'(0),
		head_item.position, head_item.mean};
	assign m_axis_tlast = head_item.block_end;

	`SRM_ASSERT_IMP(a_credit, 1'b1, occupancy <= FIFO_CW'(FIFO_DEPTH))
	`SRM_ASSERT_NXT(a_first_row, valid_s1 && first_s1, acc_s2 == ACC_BITS'($past(sample_s1)))
	`SRM_ASSERT_NXT(a_block_wrap, in_accept && last_col && last_row, col_q == '0 && row_q == '0)
endmodule
